### rtl/rrbc_pkg.sv
// Package for the random ring builder: constants, register indexes and the generator step.
package rrbc_pkg;

    localparam int unsigned MAX_ENTRIES_DEF = 65536;
    localparam int unsigned CNT_W           = 17;
    localparam int unsigned SEED_W          = 64;
    localparam int unsigned HOPS_W          = 32;
    localparam int unsigned POS_W           = 16;
    localparam int unsigned CFG_IDX_W       = 1;

    localparam logic [CNT_W-1:0]  COUNT_RESET = 17'd65536;
    localparam logic [SEED_W-1:0] SEED_RESET  = 64'h0123_4567_89AB_CDEF;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED        = 1'b1;

    // Operation codes carried in tuser
    localparam logic FUNC_BUILD = 1'b0;
    localparam logic FUNC_CHASE = 1'b1;

    // One xorshift64 step (13, 7, 17)
    function automatic logic [SEED_W-1:0] xorshift(input logic [SEED_W-1:0] x);
        logic [SEED_W-1:0] v;
        v = x ^ (x << 13);
        v = v ^ (v >> 7);
        v = v ^ (v << 17);
        return v;
    endfunction

endpackage

### rtl/random_ring_build_and_chase.sv
// Top level: random ring builder and link chaser with a shared serial modulo unit.
//
// Usage:
//  - Input stream: tuser carries the operation (build or chase), tdata the hop count.
//    A transfer is taken only while the sequencer is idle.
//  - Output stream: one position per input item, held in an output register until
//    the receiver takes it; the next item may be taken while it waits.
//  - Configuration: write entry_count (index 0) or seed (index 1) while idle.
//  - Build of n entries: fill order with the identity, then for each of n-1 shuffle
//    steps one generator step, a pass of the restoring modulo unit and the memory
//    states that read order[i] and order[j] and write them back swapped, then a read
//    and a write per entry to link the ring. The serial modulo unit (one quotient bit
//    per cycle) sets the pace of the build. The result is position 0.
//  - Chase: the modulo unit reduces the hop count by the ring size, then each hop
//    takes one registered read of the link memory. A chase before any build answers 0.
//  - Reset clears control state only; the order and link memories keep their
//    contents, and each build rewrites the entries it uses, so no clearing pass runs.
//  - When the receiver stalls, a finished result waits in the sequencer's final
//    state until the output register frees up.
module random_ring_build_and_chase #(
    parameter int unsigned MAX_ENTRIES = rrbc_pkg::MAX_ENTRIES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // slave stream
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [rrbc_pkg::HOPS_W-1:0]       i_s_axis_tdata,  // [31:0] hops
    input  logic                              i_s_axis_tuser,  // [0] func
    // master stream
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [rrbc_pkg::POS_W-1:0]        o_m_axis_tdata,  // [15:0] position
    // configuration
    input  logic                              i_cfg_we,
    input  logic [rrbc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rrbc_pkg::SEED_W-1:0]       i_cfg_data
);
    import rrbc_pkg::*;

    localparam int unsigned DEPTH = (MAX_ENTRIES < 65536) ? MAX_ENTRIES : 65536;
    localparam int unsigned AW    = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW    = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] CAP = CNT_W'(DEPTH);

    typedef enum logic [3:0] {
        ST_IDLE, ST_FILL, ST_SH_START, ST_SH_DIV, ST_SH_RDI, ST_SH_RDJ, ST_SH_WRI,
        ST_SH_WRJ, ST_LK_RD, ST_LK_WR, ST_LK_LAST, ST_CH_DIV, ST_CH_RD, ST_CH_WAIT,
        ST_DONE
    } t_state;

    // Configuration registers
    logic [CNT_W-1:0]  r_entry_count;
    logic [SEED_W-1:0] r_seed;

    // Sequencer and data path registers
    t_state            r_state;
    logic [CW-1:0]     r_size;      // ring size latched at build
    logic [CW-1:0]     r_i;         // fill / shuffle / link / hop counter
    logic [AW-1:0]     r_j;         // shuffle partner
    logic [AW-1:0]     r_oi;        // order[i] held across the swap
    logic [AW-1:0]     r_first;
    logic [AW-1:0]     r_prev;
    logic [AW-1:0]     r_pos;
    logic              r_built;
    logic [SEED_W-1:0] r_rng;
    logic [AW-1:0]     r_result;
    logic              r_out_valid;
    logic [AW-1:0]     r_out_data;

    // Shared restoring modulo unit: one quotient bit per cycle
    logic [SEED_W-1:0] r_dvd;
    logic [CNT_W-1:0]  r_dvs;
    logic [CNT_W-1:0]  r_rem;
    logic [6:0]        r_cnt;
    logic [CNT_W:0]    div_trial;
    logic              div_ge;
    logic [CNT_W-1:0]  div_rem_next;

    // Memories
    logic [AW-1:0] mem_order [DEPTH];
    logic [AW-1:0] mem_link  [DEPTH];
    logic [AW-1:0] r_ord_rdata;
    logic [AW-1:0] r_lnk_rdata;
    logic [AW-1:0] ord_raddr;
    logic          ord_we;
    logic [AW-1:0] ord_waddr;
    logic [AW-1:0] ord_wdata;
    logic          lnk_we;
    logic [AW-1:0] lnk_waddr;
    logic [AW-1:0] lnk_wdata;

    logic [CNT_W-1:0]  n_eff;
    logic [SEED_W-1:0] rng_next;
    logic              in_xfer;
    logic              out_free;

    assign in_xfer  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_out_valid || i_m_axis_tready;
    assign rng_next = xorshift(r_rng);

    // Clamp entry_count into [2, min(65536, MAX_ENTRIES)]
    always_comb begin
        if (r_entry_count < CNT_W'(2)) begin
            n_eff = CNT_W'(2);
        end else if (r_entry_count > CAP) begin
            n_eff = CAP;
        end else begin
            n_eff = r_entry_count;
        end
    end

    assign div_trial    = {r_rem, r_dvd[SEED_W-1]};
    assign div_ge       = div_trial >= {1'b0, r_dvs};
    assign div_rem_next = div_ge ? CNT_W'(div_trial - {1'b0, r_dvs}) : div_trial[CNT_W-1:0];

    // Memory port control
    always_comb begin
        ord_raddr = r_i[AW-1:0];
        ord_we    = 1'b0;
        ord_waddr = r_i[AW-1:0];
        ord_wdata = r_i[AW-1:0];
        lnk_we    = 1'b0;
        lnk_waddr = r_prev;
        lnk_wdata = r_ord_rdata;
        case (r_state)
            ST_FILL: begin
                ord_we = 1'b1;
            end
            ST_SH_RDJ: begin
                ord_raddr = r_j;
            end
            ST_SH_WRI: begin
                ord_we    = 1'b1;
                ord_wdata = r_ord_rdata;
            end
            ST_SH_WRJ: begin
                ord_we    = 1'b1;
                ord_waddr = r_j;
                ord_wdata = r_oi;
            end
            ST_LK_WR: begin
                lnk_we = (r_i != '0);
            end
            ST_LK_LAST: begin
                lnk_we    = 1'b1;
                lnk_wdata = r_first;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (ord_we) begin
            mem_order[ord_waddr] <= ord_wdata;
        end
        r_ord_rdata <= mem_order[ord_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (lnk_we) begin
            mem_link[lnk_waddr] <= lnk_wdata;
        end
        r_lnk_rdata <= mem_link[r_pos];
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= COUNT_RESET;
            r_seed        <= SEED_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ENTRY_COUNT: r_entry_count <= i_cfg_data[CNT_W-1:0];
                CFG_SEED:        r_seed        <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_built     <= 1'b0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Load a finished result, else drop the one taken by the receiver
            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_xfer) begin
                        if (i_s_axis_tuser == FUNC_BUILD) begin
                            r_size  <= CW'(n_eff);
                            r_rng   <= r_seed;
                            r_i     <= '0;
                            r_state <= ST_FILL;
                        end else if (!r_built) begin
                            r_result <= '0;
                            r_state  <= ST_DONE;
                        end else begin
                            r_dvd   <= SEED_W'(i_s_axis_tdata);
                            r_dvs   <= CNT_W'(r_size);
                            r_rem   <= '0;
                            r_cnt   <= 7'd64;
                            r_state <= ST_CH_DIV;
                        end
                    end
                end
                // Fill order with the identity
                ST_FILL: begin
                    if (r_i == r_size - CW'(1)) begin
                        r_state <= ST_SH_START;
                    end else begin
                        r_i <= r_i + CW'(1);
                    end
                end
                // Advance the generator, start the modulo by i+1
                ST_SH_START: begin
                    if (r_i == '0) begin
                        r_state <= ST_LK_RD;
                    end else begin
                        r_rng   <= rng_next;
                        r_dvd   <= rng_next;
                        r_dvs   <= CNT_W'(r_i) + CNT_W'(1);
                        r_rem   <= '0;
                        r_cnt   <= 7'd64;
                        r_state <= ST_SH_DIV;
                    end
                end
                ST_SH_DIV: begin
                    r_rem <= div_rem_next;
                    r_dvd <= r_dvd << 1;
                    r_cnt <= r_cnt - 7'd1;
                    if (r_cnt == 7'd1) begin
                        r_j     <= div_rem_next[AW-1:0];
                        r_state <= ST_SH_RDI;
                    end
                end
                ST_SH_RDI: r_state <= ST_SH_RDJ;
                ST_SH_RDJ: begin
                    r_oi    <= r_ord_rdata;
                    r_state <= ST_SH_WRI;
                end
                ST_SH_WRI: r_state <= ST_SH_WRJ;
                ST_SH_WRJ: begin
                    r_i     <= r_i - CW'(1);
                    r_state <= ST_SH_START;
                end
                // Link each shuffled entry to its successor
                ST_LK_RD: r_state <= ST_LK_WR;
                ST_LK_WR: begin
                    if (r_i == '0) begin
                        r_first <= r_ord_rdata;
                    end
                    r_prev <= r_ord_rdata;
                    if (r_i == r_size - CW'(1)) begin
                        r_state <= ST_LK_LAST;
                    end else begin
                        r_i     <= r_i + CW'(1);
                        r_state <= ST_LK_RD;
                    end
                end
                ST_LK_LAST: begin
                    r_built  <= 1'b1;
                    r_pos    <= '0;
                    r_result <= '0;
                    r_state  <= ST_DONE;
                end
                // Reduce hops modulo the ring size
                ST_CH_DIV: begin
                    r_rem <= div_rem_next;
                    r_dvd <= r_dvd << 1;
                    r_cnt <= r_cnt - 7'd1;
                    if (r_cnt == 7'd1) begin
                        r_i     <= CW'(div_rem_next);
                        r_state <= ST_CH_RD;
                    end
                end
                // Link read is issued at r_pos every cycle
                ST_CH_RD: begin
                    if (r_i == '0) begin
                        r_result <= r_pos;
                        r_state  <= ST_DONE;
                    end else begin
                        r_state <= ST_CH_WAIT;
                    end
                end
                ST_CH_WAIT: begin
                    r_pos   <= r_lnk_rdata;
                    r_i     <= r_i - CW'(1);
                    r_state <= ST_CH_RD;
                end
                // Hold until the output register is free
                ST_DONE: begin
                    if (out_free) begin
                        r_out_data  <= r_result;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = POS_W'(r_out_data);

endmodule

### rtl/rrbc_checker.sv
// Port-level checker for the random ring builder, with its bind.
module rrbc_checker #(
    parameter int unsigned MAX_ENTRIES = rrbc_pkg::MAX_ENTRIES_DEF
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_s_axis_tvalid,
    input logic                        o_s_axis_tready,
    input logic                        o_m_axis_tvalid,
    input logic                        i_m_axis_tready,
    input logic [rrbc_pkg::POS_W-1:0]  o_m_axis_tdata
);
    import rrbc_pkg::*;

    localparam int unsigned DEPTH = (MAX_ENTRIES < 65536) ? MAX_ENTRIES : 65536;

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

    // The sequencer is busy right after taking an item
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("ready stayed high after a transfer");

    // Reset leaves the block idle with no result pending
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid && o_s_axis_tready)
        else $error("not idle after reset");

    // A position always lies inside the table
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> 32'(o_m_axis_tdata) < DEPTH)
        else $error("position out of range");

endmodule

bind random_ring_build_and_chase rrbc_checker #(.MAX_ENTRIES(MAX_ENTRIES)) u_rrbc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
